// ===== hw/rtl/pthc_pkg.sv =====
`timescale 1ns / 1ps

package pthc_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Restoring divider: one quotient bit per stage
    localparam int DIV_STEPS = 64;

    // Humidity clamp, 100 %RH before the final shift
    localparam logic signed [31:0] HUM_LIMIT = 32'sd419430400;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMP      = 3'd0,
        REG_PRES_LOW  = 3'd1,
        REG_PRES_HIGH = 3'd2,
        REG_PRES_LAST = 3'd3,
        REG_HUM_LOW   = 3'd4,
        REG_HUM_HIGH  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_pres;
        logic [15:0] raw_hum;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] temp_centi_deg;
        logic signed [31:0] fine_temp;
        logic        [31:0] pres_q24_8;
        logic               pres_div_zero;
        logic        [16:0] hum_q22_10;
    } result_t;

    // Unpacked calibration coefficients
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [15:0] h4;
        logic signed [15:0] h5;
        logic signed [7:0]  h6;
    } coeff_t;

    // Finished fields that ride along with the division
    typedef struct packed {
        logic signed [31:0] tc;
        logic signed [31:0] tf;
        logic        [16:0] hum;
        logic               dz;
    } side_t;

    // One divider stage
    typedef struct packed {
        logic        valid;
        logic [31:0] rem;
        logic [63:0] nq;
        logic [31:0] md;
        logic        neg;
        side_t       side;
    } div_stage_t;

endpackage

// ===== hw/rtl/pth_sensor_compensation.sv =====
`timescale 1ns / 1ps

// Integer temperature, pressure and humidity compensation. A raw sample
// is taken on every clock where start is high (busy is always low), so
// the block sustains one sample per cycle. Each result appears on result
// with done high for exactly one cycle, after its sample has passed
// through the temperature, pressure and humidity arithmetic, the
// one-bit-per-stage pressure divider and the pressure correction stages.
// The receiver cannot hold results off, so it must capture every done
// cycle. Write the calibration registers only while no sample is in
// flight.
module pth_sensor_compensation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pthc_pkg::sample_t                   sample,
    input  logic                                cfg_write,
    input  logic [pthc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pthc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                done,
    output pthc_pkg::result_t                   result
);

    logic [47:0] temp_reg;
    logic [63:0] pres_low_reg;
    logic [63:0] pres_high_reg;
    logic [15:0] pres_last_reg;
    logic [31:0] hum_low_reg;
    logic [39:0] hum_high_reg;

    // Hold calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg      <= '0;
            pres_low_reg  <= '0;
            pres_high_reg <= '0;
            pres_last_reg <= '0;
            hum_low_reg   <= '0;
            hum_high_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (pthc_pkg::cfg_reg_t'(cfg_index))
                pthc_pkg::REG_TEMP:      temp_reg      <= cfg_data[47:0];
                pthc_pkg::REG_PRES_LOW:  pres_low_reg  <= cfg_data;
                pthc_pkg::REG_PRES_HIGH: pres_high_reg <= cfg_data;
                pthc_pkg::REG_PRES_LAST: pres_last_reg <= cfg_data[15:0];
                pthc_pkg::REG_HUM_LOW:   hum_low_reg   <= cfg_data[31:0];
                pthc_pkg::REG_HUM_HIGH:  hum_high_reg  <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    pthc_pkg::coeff_t coeff;

    always_comb
    begin
        coeff.t1 = temp_reg[15:0];
        coeff.t2 = temp_reg[31:16];
        coeff.t3 = temp_reg[47:32];
        coeff.p1 = pres_low_reg[15:0];
        coeff.p2 = pres_low_reg[31:16];
        coeff.p3 = pres_low_reg[47:32];
        coeff.p4 = pres_low_reg[63:48];
        coeff.p5 = pres_high_reg[15:0];
        coeff.p6 = pres_high_reg[31:16];
        coeff.p7 = pres_high_reg[47:32];
        coeff.p8 = pres_high_reg[63:48];
        coeff.p9 = pres_last_reg;
        coeff.h1 = hum_low_reg[7:0];
        coeff.h2 = hum_low_reg[23:8];
        coeff.h3 = hum_low_reg[31:24];
        coeff.h4 = hum_high_reg[15:0];
        coeff.h5 = hum_high_reg[31:16];
        coeff.h6 = hum_high_reg[39:32];
    end

    assign busy = 1'b0;

    pthc_pkg::div_stage_t div_in;
    pthc_pkg::div_stage_t div_out;

    pthc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .sample   (sample),
        .coeff    (coeff),
        .div_in   (div_in)
    );

    pthc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_in  (div_in),
        .div_out (div_out)
    );

    pthc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_out (div_out),
        .coeff   (coeff),
        .done    (done),
        .result  (result)
    );

`ifndef SYNTH
    // Zero divisor forces zero pressure
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.pres_div_zero |-> result.pres_q24_8 == 32'd0)
        else $error("pressure not zero on zero divisor");

    // Humidity stays within 0..100 %RH
    a_hum_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.hum_q22_10 <= 17'd102400)
        else $error("humidity above limit");

    // Temperature fields of one transfer stay aligned through the pipeline
    a_temp_align: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.temp_centi_deg ==
        ((result.fine_temp * 32'sd5 + 32'sd128) >>> 8))
        else $error("temperature fields misaligned");
`endif

endmodule

// ===== hw/rtl/pthc_front.sv =====
`timescale 1ns / 1ps

module pthc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  pthc_pkg::sample_t      sample,
    input  pthc_pkg::coeff_t       coeff,
    output pthc_pkg::div_stage_t   div_in
);

    // Sign- or zero-extended coefficients
    logic signed [31:0] t1_w, t2_w, t3_w;
    logic signed [31:0] h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;
    logic signed [63:0] p4_w;

    assign t1_w = $signed({16'd0, coeff.t1});
    assign t2_w = coeff.t2;
    assign t3_w = coeff.t3;
    assign h1_w = $signed({24'd0, coeff.h1});
    assign h2_w = coeff.h2;
    assign h3_w = $signed({24'd0, coeff.h3});
    assign h4_w = coeff.h4;
    assign h5_w = coeff.h5;
    assign h6_w = coeff.h6;
    assign p4_w = coeff.p4;

    logic [7:0] vld_reg;

    // Stage 1: temperature products
    logic signed [31:0] a_w, d_w;
    logic signed [31:0] v1_next, v1_reg, dd_next, dd_reg;
    logic [19:0] ap1_reg;
    logic [15:0] ah1_reg;

    assign a_w     = $signed({15'd0, sample.raw_temp[19:3]}) - (t1_w <<< 1);
    assign d_w     = $signed({16'd0, sample.raw_temp[19:4]}) - t1_w;
    assign v1_next = (a_w * t2_w) >>> 11;
    assign dd_next = d_w * d_w;

    always_ff @(posedge clk)
    begin
        v1_reg  <= v1_next;
        dd_reg  <= dd_next;
        ap1_reg <= sample.raw_pres;
        ah1_reg <= sample.raw_hum;
    end

    // Stage 2: fine temperature
    logic signed [31:0] tf_next, tf2_reg;
    logic [19:0] ap2_reg;
    logic [15:0] ah2_reg;

    assign tf_next = v1_reg + ((((dd_reg >>> 12) * t3_w)) >>> 14);

    always_ff @(posedge clk)
    begin
        tf2_reg <= tf_next;
        ap2_reg <= ap1_reg;
        ah2_reg <= ah1_reg;
    end

    // Stage 3: centidegrees, first pressure and humidity products
    logic signed [31:0] tc_next, tc3_reg, tf3_reg;
    logic signed [33:0] x1_w;
    logic signed [67:0] xsq_full;
    logic signed [49:0] x1p5_next, x1p5_reg, x1p2_next, x1p2_reg;
    logic signed [63:0] xsq_reg;
    logic signed [31:0] hx_w, hx5_next, hx5_reg, xh6_next, xh6_reg, xh3_next, xh3_reg;
    logic [19:0] ap3_reg;
    logic [15:0] ah3_reg;

    assign tc_next   = (tf2_reg * 32'sd5 + 32'sd128) >>> 8;
    assign x1_w      = {{2{tf2_reg[31]}}, tf2_reg} - 34'sd128000;
    assign xsq_full  = x1_w * x1_w;
    assign x1p5_next = x1_w * coeff.p5;
    assign x1p2_next = x1_w * coeff.p2;
    assign hx_w      = tf2_reg - 32'sd76800;
    assign hx5_next  = h5_w * hx_w;
    assign xh6_next  = (hx_w * h6_w) >>> 10;
    assign xh3_next  = ((hx_w * h3_w) >>> 11) + 32'sd32768;

    always_ff @(posedge clk)
    begin
        tc3_reg  <= tc_next;
        tf3_reg  <= tf2_reg;
        xsq_reg  <= xsq_full[63:0];
        x1p5_reg <= x1p5_next;
        x1p2_reg <= x1p2_next;
        hx5_reg  <= hx5_next;
        xh6_reg  <= xh6_next;
        xh3_reg  <= xh3_next;
        ap3_reg  <= ap2_reg;
        ah3_reg  <= ah2_reg;
    end

    // Stage 4: coefficient products on the square, humidity terms
    logic signed [79:0] x2a_full, xp3_full;
    logic signed [63:0] x2a_reg, xp3_reg;
    logic signed [49:0] x1p5_4_reg, x1p2_4_reg;
    logic signed [31:0] ta_next, ta4_reg, tb0_next, tb0_reg, tc4_reg, tf4_reg;
    logic [19:0] ap4_reg;

    assign x2a_full = xsq_reg * coeff.p6;
    assign xp3_full = xsq_reg * coeff.p3;
    assign ta_next  = ($signed({2'b00, ah3_reg, 14'd0}) - (h4_w <<< 20) - hx5_reg
                       + 32'sd16384) >>> 15;
    assign tb0_next = ((xh6_reg * xh3_reg) >>> 10) + 32'sd2097152;

    always_ff @(posedge clk)
    begin
        x2a_reg    <= x2a_full[63:0];
        xp3_reg    <= xp3_full[63:0];
        x1p5_4_reg <= x1p5_reg;
        x1p2_4_reg <= x1p2_reg;
        ta4_reg    <= ta_next;
        tb0_reg    <= tb0_next;
        tc4_reg    <= tc3_reg;
        tf4_reg    <= tf3_reg;
        ap4_reg    <= ap3_reg;
    end

    // Stage 5: pressure sums, humidity scale
    logic signed [63:0] x1p5_w, x1p2_w, x2_next, x2_reg, x1b_next, x1b_reg;
    logic signed [31:0] tb_next, tb_reg, ta5_reg, tc5_reg, tf5_reg;
    logic [19:0] ap5_reg;

    assign x1p5_w   = x1p5_4_reg;
    assign x1p2_w   = x1p2_4_reg;
    assign x2_next  = x2a_reg + (x1p5_w <<< 17) + (p4_w <<< 35);
    assign x1b_next = (xp3_reg >>> 8) + (x1p2_w <<< 12);
    assign tb_next  = (tb0_reg * h2_w + 32'sd8192) >>> 14;

    always_ff @(posedge clk)
    begin
        x2_reg  <= x2_next;
        x1b_reg <= x1b_next;
        tb_reg  <= tb_next;
        ta5_reg <= ta4_reg;
        tc5_reg <= tc4_reg;
        tf5_reg <= tf4_reg;
        ap5_reg <= ap4_reg;
    end

    // Stage 6: divisor and raw numerator, humidity product
    logic [63:0] den_base;
    logic [79:0] den_full;
    logic signed [63:0] den_next, den6_reg;
    logic [20:0] pres_inv;
    logic [63:0] num0_next, num0_reg;
    logic signed [31:0] v_next, v6_reg, tc6_reg, tf6_reg;

    assign den_base  = x1b_reg + 64'h0000_8000_0000_0000;
    assign den_full  = den_base * coeff.p1;
    assign den_next  = $signed(den_full[63:0]) >>> 33;
    assign pres_inv  = 21'd1048576 - {1'b0, ap5_reg};
    assign num0_next = {12'd0, pres_inv, 31'd0} - x2_reg;
    assign v_next    = ta5_reg * tb_reg;

    always_ff @(posedge clk)
    begin
        den6_reg <= den_next;
        num0_reg <= num0_next;
        v6_reg   <= v_next;
        tc6_reg  <= tc5_reg;
        tf6_reg  <= tf5_reg;
    end

    // Stage 7: scale numerator, humidity square
    logic [75:0] num_full;
    logic [63:0] num_reg;
    logic signed [63:0] den7_reg;
    logic signed [31:0] q_w, qq_next, qq_reg, v7_reg, tc7_reg, tf7_reg;

    assign num_full = num0_reg * 12'd3125;
    assign q_w      = v6_reg >>> 15;
    assign qq_next  = (q_w * q_w) >>> 7;

    always_ff @(posedge clk)
    begin
        num_reg  <= num_full[63:0];
        den7_reg <= den6_reg;
        qq_reg   <= qq_next;
        v7_reg   <= v6_reg;
        tc7_reg  <= tc6_reg;
        tf7_reg  <= tf6_reg;
    end

    // Stage 8: operand magnitudes and sign, humidity correction
    logic [63:0] den_mag;
    logic [63:0] mn_next, mn_reg;
    logic [31:0] md_reg;
    logic        neg_reg, dz_reg;
    logic signed [31:0] sub_next, sub_reg, v8_reg, tc8_reg, tf8_reg;

    assign den_mag  = 64'd0 - den7_reg;
    assign mn_next  = num_reg[63] ? (64'd0 - num_reg) : num_reg;
    assign sub_next = (qq_reg * h1_w) >>> 4;

    always_ff @(posedge clk)
    begin
        mn_reg  <= mn_next;
        md_reg  <= den7_reg[63] ? den_mag[31:0] : den7_reg[31:0];
        neg_reg <= num_reg[63] ^ den7_reg[63];
        dz_reg  <= (den7_reg == 64'sd0);
        sub_reg <= sub_next;
        v8_reg  <= v7_reg;
        tc8_reg <= tc7_reg;
        tf8_reg <= tf7_reg;
    end

    // Stage 9: clamp humidity, hand off to divider
    logic signed [31:0] vd_w, vc_w;
    pthc_pkg::div_stage_t div_next, div_reg;

    always_comb
    begin
        vd_w = v8_reg - sub_reg;
        vc_w = vd_w;
        if (vd_w < 32'sd0)
        begin
            vc_w = 32'sd0;
        end
        if (vd_w > pthc_pkg::HUM_LIMIT)
        begin
            vc_w = pthc_pkg::HUM_LIMIT;
        end
        div_next          = '0;
        div_next.valid    = vld_reg[7];
        div_next.rem      = 32'd0;
        div_next.nq       = mn_reg;
        div_next.md       = md_reg;
        div_next.neg      = neg_reg;
        div_next.side.tc  = tc8_reg;
        div_next.side.tf  = tf8_reg;
        div_next.side.hum = vc_w[28:12];
        div_next.side.dz  = dz_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            div_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
            div_reg <= div_next;
        end
    end

    assign div_in = div_reg;

endmodule

// ===== hw/rtl/pthc_div.sv =====
`timescale 1ns / 1ps

module pthc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pthc_pkg::div_stage_t div_in,
    output pthc_pkg::div_stage_t div_out
);

    pthc_pkg::div_stage_t stage_reg [pthc_pkg::DIV_STEPS+1];

    assign stage_reg[0] = div_in;

    // One restoring step per stage
    for (genvar i = 0; i < pthc_pkg::DIV_STEPS; i++)
    begin : g_step
        logic [32:0] trial;
        logic [32:0] diff;
        pthc_pkg::div_stage_t step_next;

        always_comb
        begin
            trial        = {stage_reg[i].rem, stage_reg[i].nq[63]};
            diff         = trial - {1'b0, stage_reg[i].md};
            step_next    = stage_reg[i];
            step_next.nq = {stage_reg[i].nq[62:0], ~diff[32]};
            step_next.rem = diff[32] ? trial[31:0] : diff[31:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[i+1] <= '0;
            end
            else
            begin
                stage_reg[i+1] <= step_next;
            end
        end
    end

    assign div_out = stage_reg[pthc_pkg::DIV_STEPS];

`ifndef SYNTH
    // Partial remainder stays below a nonzero divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        div_out.valid && div_out.md != 32'd0 |-> div_out.rem < div_out.md)
        else $error("divider remainder not below divisor");

    // Valid bit moves one stage per clock at the output
    a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg[pthc_pkg::DIV_STEPS-1].valid |=> div_out.valid)
        else $error("divider valid bit lost");

    // Divisor travels unchanged with its item
    a_md_held: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg[pthc_pkg::DIV_STEPS-1].valid |=>
        div_out.md == $past(stage_reg[pthc_pkg::DIV_STEPS-1].md))
        else $error("divisor changed in flight");
`endif

endmodule

// ===== hw/rtl/pthc_back.sv =====
`timescale 1ns / 1ps

module pthc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pthc_pkg::div_stage_t div_out,
    input  pthc_pkg::coeff_t     coeff,
    output logic                 done,
    output pthc_pkg::result_t    result
);

    logic [4:0] vld_reg;
    pthc_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg;

    // Stage 1: apply quotient sign
    logic signed [63:0] p1_reg;

    always_ff @(posedge clk)
    begin
        p1_reg    <= div_out.neg ? $signed(64'd0 - div_out.nq) : $signed(div_out.nq);
        side1_reg <= div_out.side;
    end

    // Stage 2: scaled quotient and coefficient products
    logic signed [63:0] s_w;
    logic signed [79:0] ps9_full, py2_full;
    logic signed [63:0] y2_w;
    logic signed [63:0] s2_reg, ps9_reg, y2_reg, p2_reg;

    assign s_w      = p1_reg >>> 13;
    assign ps9_full = s_w * coeff.p9;
    assign py2_full = p1_reg * coeff.p8;
    assign y2_w     = $signed(py2_full[63:0]) >>> 19;

    always_ff @(posedge clk)
    begin
        s2_reg    <= s_w;
        ps9_reg   <= ps9_full[63:0];
        y2_reg    <= y2_w;
        p2_reg    <= p1_reg;
        side2_reg <= side1_reg;
    end

    // Stage 3: partial products of the square term
    logic [63:0] ll_w, hl_w, lh_w;
    logic [63:0] ll_reg;
    logic [31:0] hl_reg, lh_reg;
    logic signed [63:0] y2_3_reg, p3_reg;

    assign ll_w = ps9_reg[31:0] * s2_reg[31:0];
    assign hl_w = ps9_reg[63:32] * s2_reg[31:0];
    assign lh_w = ps9_reg[31:0] * s2_reg[63:32];

    always_ff @(posedge clk)
    begin
        ll_reg    <= ll_w;
        hl_reg    <= hl_w[31:0];
        lh_reg    <= lh_w[31:0];
        y2_3_reg  <= y2_reg;
        p3_reg    <= p2_reg;
        side3_reg <= side2_reg;
    end

    // Stage 4: sum correction terms
    logic [63:0] sq_w;
    logic [31:0] cross_w;
    logic signed [63:0] y1_w, sum_reg;

    assign cross_w = hl_reg + lh_reg;
    assign sq_w    = ll_reg + {cross_w, 32'd0};
    assign y1_w    = $signed(sq_w) >>> 25;

    always_ff @(posedge clk)
    begin
        sum_reg   <= p3_reg + y1_w + y2_3_reg;
        side4_reg <= side3_reg;
    end

    // Stage 5: final pressure and result register
    logic signed [63:0] p7_w, pres_w;
    pthc_pkg::result_t result_next, result_reg;

    assign p7_w   = coeff.p7;
    assign pres_w = (sum_reg >>> 8) + (p7_w <<< 4);

    always_comb
    begin
        result_next.temp_centi_deg = side4_reg.tc;
        result_next.fine_temp      = side4_reg.tf;
        result_next.pres_q24_8     = side4_reg.dz ? 32'd0 : pres_w[31:0];
        result_next.pres_div_zero  = side4_reg.dz;
        result_next.hum_q22_10     = side4_reg.hum;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], div_out.valid};
        end
    end

    assign done   = vld_reg[4];
    assign result = result_reg;

endmodule
